>>> src/cflt_pkg.sv
package cflt_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_REWIND = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_ROW      = 2'd1,
    ST_END      = 2'd2,
    ST_REWOUND  = 2'd3
  } status_t;

  localparam int InDataW  = 160;
  localparam int RowW     = 192;

  // field order from the lowest bit up matches the stream packing
  typedef struct packed {
    logic [31:0] count;
    logic [7:0]  reason;
    logic [15:0] dport;
    logic [15:0] sport;
    logic [31:0] dip;
    logic [31:0] sip;
    logic [7:0]  hook;
    logic [7:0]  action;
    logic [7:0]  protocol;
    logic [31:0] time_s;
  } row_t;

  typedef struct packed {
    logic latch;
    logic srch_rd;
    logic srch_next;
    logic found;
    logic miss;
    logic sh_rd;
    logic sh_wr;
    logic head;
    logic rd_issue;
    logic rd_out;
    logic rd_end;
    logic rewind;
    logic clear;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic idx_end;
    logic idx_zero;
    logic match;
    logic rank_end;
    logic out_free;
  } stat_t;

endpackage

>>> src/coalescing_flow_log_table.sv
// sequence, from the accept: rewind, clear and read at end emit from dispatch; a read of a row
// reads the memory, then registers the row; an insert scans the rows from rank 0 for a match,
// then moves rows down one rank, one row at a time (the s rows above a match at rank s, or on a
// miss m = min(n, LOG_DEPTH-1) rows, n the row count) and writes the new head; set by the single-
// port row memory; a result still waiting on m_axis_tready holds back emitting the next result
// throughput: one transaction at a time, next accepted after the result is registered
// reset: synchronous, empties the table and rewinds the cursor, no memory clearing pass
module coalescing_flow_log_table #(
  parameter int LOG_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // timestamp, protocol, action, hook_number, source_ip, dest_ip, source_port,
  // dest_port, reason_code
  input  logic [159:0]         s_axis_tdata,
  // opcode
  input  logic [1:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // row_time, row_protocol, row_action, row_hook, row_source_ip, row_dest_ip,
  // row_source_port, row_dest_port, row_reason, hit_count, rows_stored
  output logic [((192 + $clog2(LOG_DEPTH + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // status
  output logic [1:0]           m_axis_tuser
);
  import cflt_pkg::*;

  localparam int CW   = $clog2(LOG_DEPTH + 1);
  localparam int OutW = ((RowW + CW + 7) / 8) * 8;

  cmd_t          cmd;
  stat_t         st;
  status_t       out_status;
  row_t          out_row;
  logic [CW-1:0] out_total;
  logic [CW-1:0] total_q;

  cflt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  cflt_data #(
    .LOG_DEPTH (LOG_DEPTH),
    .CW        (CW)
  ) u_data (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .in_op      (s_axis_tuser),
    .in_data    (s_axis_tdata),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (out_status),
    .out_row    (out_row),
    .out_total  (out_total),
    .total_q    (total_q)
  );

  assign m_axis_tdata = OutW'({out_total, out_row});
  assign m_axis_tuser = out_status;

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total_q <= CW'(LOG_DEPTH))
    else $error("row total above depth");

  a_insert_nonempty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_status == ST_INSERTED |-> out_total != '0 && out_row.count != '0)
    else $error("insert result with empty table or zero count");

  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (out_status == ST_END || out_status == ST_REWOUND) |->
      out_row == '0)
    else $error("non-row result carries row data");

  a_single_cmd: assert property (@(posedge clk) disable iff (rst)
    $countones(cmd) <= 1)
    else $error("controller issued more than one command");

endmodule

>>> src/cflt_ctrl.sv
module cflt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cflt_pkg::stat_t st,
  output cflt_pkg::cmd_t  cmd
);
  import cflt_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DISP     = 8'b0000_0010,
    S_SRCH_RD  = 8'b0000_0100,
    S_SRCH_CMP = 8'b0000_1000,
    S_SH_RD    = 8'b0001_0000,
    S_SH_WR    = 8'b0010_0000,
    S_HEAD     = 8'b0100_0000,
    S_RD_OUT   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        unique case (st.op)
          OP_INSERT: state_next = S_SRCH_RD;
          OP_READ: begin
            if (!st.rank_end) begin
              cmd.rd_issue = 1'b1;
              state_next = S_RD_OUT;
            end else if (st.out_free) begin
              cmd.rd_end = 1'b1;
              state_next = S_IDLE;
            end
          end
          OP_REWIND: begin
            if (st.out_free) begin
              cmd.rewind = 1'b1;
              state_next = S_IDLE;
            end
          end
          default: begin
            if (st.out_free) begin
              cmd.clear = 1'b1;
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_SRCH_RD: begin
        if (st.idx_end) begin
          cmd.miss = 1'b1;
          state_next = S_SH_RD;
        end else begin
          cmd.srch_rd = 1'b1;
          state_next = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (st.match) begin
          cmd.found = 1'b1;
          state_next = S_SH_RD;
        end else begin
          cmd.srch_next = 1'b1;
          state_next = S_SRCH_RD;
        end
      end
      S_SH_RD: begin
        if (st.idx_zero) begin
          state_next = S_HEAD;
        end else begin
          cmd.sh_rd = 1'b1;
          state_next = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd.sh_wr = 1'b1;
        state_next = S_SH_RD;
      end
      S_HEAD: begin
        if (st.out_free) begin
          cmd.head = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RD_OUT: begin
        if (st.out_free) begin
          cmd.rd_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> src/cflt_data.sv
module cflt_data #(
  parameter int LOG_DEPTH = 64,
  parameter int CW = 7
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cflt_pkg::cmd_t             cmd,
  output cflt_pkg::stat_t            st,
  input  logic [1:0]                 in_op,
  input  logic [cflt_pkg::InDataW-1:0] in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output cflt_pkg::status_t          out_status,
  output cflt_pkg::row_t             out_row,
  output logic [CW-1:0]              out_total,
  output logic [CW-1:0]              total_q
);
  import cflt_pkg::*;

  localparam int IW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;

  row_t          mem [LOG_DEPTH];
  row_t          rdata;
  row_t          item;
  op_t           op;
  logic [CW-1:0] total, rank, idx;
  logic [31:0]   cnt;
  logic          found;
  logic [CW-1:0] idx_dec;
  logic [CW-1:0] rd_addr;
  logic          re, we;
  logic [IW-1:0] wa;
  row_t          wd;
  logic [CW-1:0] head_total;
  logic          emit;

  assign idx_dec = idx - CW'(1);
  assign total_q = total;
  assign emit = cmd.head | cmd.rd_out | cmd.rd_end | cmd.rewind | cmd.clear;

  always_comb begin
    rd_addr = idx;
    if (cmd.sh_rd) rd_addr = idx_dec;
    else if (cmd.rd_issue) rd_addr = rank;
  end

  assign re = cmd.srch_rd | cmd.sh_rd | cmd.rd_issue;
  assign we = cmd.sh_wr | cmd.head;
  assign wa = cmd.head ? '0 : idx[IW-1:0];

  always_comb begin
    wd = rdata;
    if (cmd.head) begin
      wd = item;
      wd.count = cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rdata <= mem[rd_addr[IW-1:0]];
  end

  assign head_total = (found || total == CW'(LOG_DEPTH)) ? total : total + CW'(1);

  assign st.op       = op;
  assign st.idx_end  = (idx == total);
  assign st.idx_zero = (idx == '0);
  assign st.rank_end = (rank >= total);
  assign st.out_free = !out_valid || out_ready;
  assign st.match    = rdata.protocol == item.protocol && rdata.action == item.action &&
                       rdata.hook == item.hook && rdata.sip == item.sip &&
                       rdata.dip == item.dip && rdata.sport == item.sport &&
                       rdata.dport == item.dport && rdata.reason == item.reason;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op   <= op_t'(in_op);
      item <= row_t'({32'd0, in_data});
    end
    if (cmd.found) begin
      cnt <= (rdata.count == 32'hFFFF_FFFF) ? rdata.count : rdata.count + 32'd1;
    end else if (cmd.miss) begin
      cnt <= 32'd1;
    end
    if (emit) begin
      if (cmd.head) begin
        out_status <= ST_INSERTED;
        out_row    <= wd;
        out_total  <= head_total;
      end else if (cmd.rd_out) begin
        out_status <= ST_ROW;
        out_row    <= rdata;
        out_total  <= total;
      end else if (cmd.rd_end) begin
        out_status <= ST_END;
        out_row    <= '0;
        out_total  <= total;
      end else begin
        out_status <= ST_REWOUND;
        out_row    <= '0;
        out_total  <= cmd.clear ? '0 : total;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      rank      <= '0;
      idx       <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit || (out_valid && !out_ready);
      if (cmd.latch) begin
        idx   <= '0;
        found <= 1'b0;
      end
      if (cmd.srch_next) idx <= idx + CW'(1);
      if (cmd.found) found <= 1'b1;
      if (cmd.miss) idx <= (total == CW'(LOG_DEPTH)) ? CW'(LOG_DEPTH - 1) : total;
      if (cmd.sh_wr) idx <= idx_dec;
      if (cmd.head) total <= head_total;
      if (cmd.rd_out) rank <= rank + CW'(1);
      if (cmd.rd_end || cmd.rewind) rank <= '0;
      if (cmd.clear) begin
        total <= '0;
        rank  <= '0;
      end
    end
  end

endmodule

>>> tb/tb_coalescing_flow_log_table.sv
module tb_coalescing_flow_log_table;
  import cflt_pkg::*;

  localparam int Depth = 64;
  localparam int OutW = ((192 + $clog2(Depth + 1) + 7) / 8) * 8;
  localparam int CycleLimit = 2000000;

  typedef struct {
    status_t    st;
    row_t       row;
    logic [6:0] stored;
  } log_result_t;

  class flow_log_scoreboard;
    row_t        rows[Depth];
    int          row_count;
    int          cursor;
    log_result_t pending[$];
    int          errors;

    function new();
      row_count = 0;
      cursor = 0;
      errors = 0;
    endfunction

    function bit same_flow(row_t a, row_t b);
      return {a.protocol, a.action, a.hook, a.sip, a.dip, a.sport, a.dport, a.reason} ==
             {b.protocol, b.action, b.hook, b.sip, b.dip, b.sport, b.dport, b.reason};
    endfunction

    function void note_input(op_t op, logic [159:0] d);
      log_result_t r;
      row_t e;
      r.row = '0;
      case (op)
        OP_INSERT: begin
          e = '0;
          e.time_s = d[31:0];
          e.protocol = d[39:32];
          e.action = d[47:40];
          e.hook = d[55:48];
          e.sip = d[87:56];
          e.dip = d[119:88];
          e.sport = d[135:120];
          e.dport = d[151:136];
          e.reason = d[159:152];
          e.count = 32'd1;
          for (int i = 0; i < row_count; i++) begin
            if (same_flow(rows[i], e)) begin
              e.count = (rows[i].count == 32'hffffffff) ? rows[i].count : rows[i].count + 1;
              for (int j = i; j + 1 < row_count; j++) rows[j] = rows[j + 1];
              row_count--;
              break;
            end
          end
          if (row_count >= Depth) row_count = Depth - 1;
          for (int i = row_count; i > 0; i--) rows[i] = rows[i - 1];
          rows[0] = e;
          row_count++;
          r.st = ST_INSERTED;
          r.row = e;
        end
        OP_READ: begin
          if (cursor >= row_count) begin
            cursor = 0;
            r.st = ST_END;
          end else begin
            r.st = ST_ROW;
            r.row = rows[cursor];
            cursor++;
          end
        end
        OP_REWIND: begin
          cursor = 0;
          r.st = ST_REWOUND;
        end
        default: begin
          row_count = 0;
          cursor = 0;
          r.st = ST_REWOUND;
        end
      endcase
      r.stored = row_count[6:0];
      pending.push_back(r);
    endfunction

    function void field(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $display("%0t: %s expected %h actual %h", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_result(logic [1:0] st, logic [OutW-1:0] d);
      log_result_t r;
      row_t a;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status %h data %h", $time, st, d);
        errors++;
        return;
      end
      r = pending.pop_front();
      a = d[191:0];
      field("status", 32'(r.st), 32'(st));
      field("row_time", r.row.time_s, a.time_s);
      field("row_protocol", 32'(r.row.protocol), 32'(a.protocol));
      field("row_action", 32'(r.row.action), 32'(a.action));
      field("row_hook", 32'(r.row.hook), 32'(a.hook));
      field("row_source_ip", r.row.sip, a.sip);
      field("row_dest_ip", r.row.dip, a.dip);
      field("row_source_port", 32'(r.row.sport), 32'(a.sport));
      field("row_dest_port", 32'(r.row.dport), 32'(a.dport));
      field("row_reason", 32'(r.row.reason), 32'(a.reason));
      field("hit_count", r.row.count, a.count);
      field("rows_stored", 32'(r.stored), 32'(d[198:192]));
    endfunction
  endclass

  logic            clk = 0;
  logic            rst = 1;
  logic            s_axis_tvalid = 0;
  logic            s_axis_tready;
  logic [159:0]    s_axis_tdata = '0;
  logic [1:0]      s_axis_tuser = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 0;
  logic [OutW-1:0] m_axis_tdata;
  logic [1:0]      m_axis_tuser;

  flow_log_scoreboard sb = new();
  logic [159:0] flow_pool[80];
  int cycles = 0;
  int stall_mode = 0;
  int burst_left = 0;

  coalescing_flow_log_table #(.LOG_DEPTH(Depth)) u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver stalls: phases of always-ready, light and heavy backpressure
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
  end

  task automatic send(op_t op, logic [159:0] d);
    if (burst_left == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tuser = op;
    s_axis_tdata = d;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(op, d);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  function automatic logic [159:0] random_flow();
    return {$urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  initial begin
    logic [159:0] d;
    int pick;
    for (int i = 0; i < 80; i++) flow_pool[i] = random_flow();
    repeat (5) @(negedge clk);
    rst = 0;

    send(OP_READ, '0);
    send(OP_INSERT, '0);
    send(OP_INSERT, '1);
    send(OP_INSERT, {8'h80, 152'h0});
    send(OP_INSERT, {8'h7f, 152'h0});
    send(OP_INSERT, {8'h7f, 120'h0, 32'h1234});
    send(OP_READ, '0);
    send(OP_INSERT, {8'h55, 152'h0});
    send(OP_READ, '0);
    send(OP_READ, '0);
    send(OP_READ, '0);
    send(OP_READ, '0);
    send(OP_READ, '0);
    send(OP_READ, '0);
    send(OP_READ, '1);
    send(OP_REWIND, '1);
    send(OP_READ, '0);
    send(OP_CLEAR, '1);
    send(OP_READ, '0);
    send(OP_INSERT, '1);

    for (int n = 0; n < 900; n++) begin
      if (n == 450) begin
        s_axis_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        if ($urandom_range(0, 9) < 7) begin
          d = flow_pool[$urandom_range(0, 79)];
          d[31:0] = $urandom;
        end else begin
          d = random_flow();
        end
        send(OP_INSERT, d);
      end else if (pick < 90) begin
        send(OP_READ, random_flow());
      end else if (pick < 98) begin
        send(OP_REWIND, random_flow());
      end else begin
        send(OP_CLEAR, random_flow());
      end
    end

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/cflt_pkg.sv
src/cflt_ctrl.sv
src/cflt_data.sv
src/coalescing_flow_log_table.sv
tb/tb_coalescing_flow_log_table.sv
